@@ rtl/confidence_filtered_bimodal_predictor_core_defines.svh @@
// Assertion macros for the confidence-filtered bimodal predictor.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef CONFIDENCE_FILTERED_BIMODAL_PREDICTOR_CORE_DEFINES_SVH
`define CONFIDENCE_FILTERED_BIMODAL_PREDICTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfbp assertion failed");
`define CFBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfbp assertion failed");
`else
`define CFBP_ASSERT_NOW(label, clk, rst, ante, cons)
`define CFBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cfbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the bimodal predictor.
// No dependencies.
package cfbp_pkg;

  localparam int CNT_W  = 8;
  localparam int CFG_W  = 4;
  localparam int ADDR_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic op;
    logic pp;
    logic taken;
    logic squashed;
  } item_info_t;

  // 0 acts as 1, anything above 8 acts as 8
  function automatic logic [CFG_W-1:0] eff_bits(input logic [CFG_W-1:0] bits);
    logic [CFG_W-1:0] r;
    r = bits;
    if (bits == 4'd0) begin
      r = 4'd1;
    end else if (bits > 4'd8) begin
      r = 4'd8;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_max(input logic [CFG_W-1:0] bits);
    logic [CFG_W-1:0] sh;
    sh = 4'd8 - bits;
    return 8'hFF >> sh;
  endfunction

endpackage

@@ rtl/confidence_filtered_bimodal_predictor_core.sv @@
`timescale 1ns / 1ps
// Confidence-filtered bimodal predictor, top level.
// Depends on cfbp_pkg, cfbp_index, cfbp_table and the assertion header.
//
// Use: s_* carries one beat per lookup (s_tuser = 0) or training update
// (s_tuser = 1). A lookup yields one beat on m_*; an update yields none.
// cfg_wen/cfg_wdata set the counter width (reset 2); write only when idle.
// An accepted lookup passes the execute stage and then the output register;
// when TABLE_ENTRIES is not a power of two the index unit first computes
// a reciprocal-multiply remainder through its MUL, QUO and RMD states.
// Throughput: one beat per cycle for power-of-two tables, unless clearing
// or stalled, since a counter read, modify and write back overlaps the next read
// with forwarding; else the index unit takes a new address only when idle.
// Reset: after rst falls the counter memory is swept to zero, one entry a
// cycle, over all TABLE_ENTRIES entries; s_tready stays low throughout for a
// power-of-two table, other sizes may take in and hold one beat.
// Stall: a lookup waits in the execute stage while the output register is
// full and m_tready is low, and s_tready drops behind it.
`include "confidence_filtered_bimodal_predictor_core_defines.svh"
module confidence_filtered_bimodal_predictor_core #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int INDEX_SHIFT   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // branch_address[31:0], perceptron_prediction[32],
                                 // taken[33], squashed[34], zero[39:35]
  input  logic        s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // predicted_taken[0], used_perceptron[1], zero[7:2]
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata  // counter_bits
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = cfbp_pkg::CNT_W;

  cfbp_pkg::item_info_t in_info;
  cfbp_pkg::item_info_t idx_info;
  logic                 idx_valid;
  logic                 idx_ready;
  logic [IW-1:0]        idx_index;
  logic                 issue;
  logic                 clr_busy;
  logic [CW-1:0]        rd_data;

  logic [cfbp_pkg::CFG_W-1:0] counter_bits;

  logic                 s1_valid;
  logic [IW-1:0]        s1_index;
  cfbp_pkg::item_info_t s1_info;
  logic                 s1_fwd;
  logic [CW-1:0]        s1_fwd_data;
  logic                 s1_done;

  logic                 out_pred;
  logic                 out_used;

  logic [cfbp_pkg::CFG_W-1:0] bits;
  logic [CW-1:0]        maxv;
  logic [CW-1:0]        lower;
  logic [CW-1:0]        upper;
  logic [CW-1:0]        cur;
  logic [CW-1:0]        cnt_next;
  logic                 unconf;
  logic                 top_set;
  logic                 pred;
  logic                 is_lookup;
  logic                 wr_en;
  logic                 step_ok;

  assign in_info.op       = s_tuser;
  assign in_info.pp       = s_tdata[32];
  assign in_info.taken    = s_tdata[33];
  assign in_info.squashed = s_tdata[34];

  cfbp_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .INDEX_SHIFT  (INDEX_SHIFT),
    .IW           (IW)
  ) u_index (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_addr  (s_tdata[31:0]),
    .in_info  (in_info),
    .out_valid(idx_valid),
    .out_ready(idx_ready),
    .out_index(idx_index),
    .out_info (idx_info)
  );

  cfbp_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IW           (IW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .clr_busy(clr_busy),
    .rd_en   (issue),
    .rd_addr (idx_index),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_index),
    .wr_data (cnt_next)
  );

  // execute stage: classify or train the counter just read
  assign is_lookup = (s1_info.op == cfbp_pkg::OP_LOOKUP);
  assign cur       = s1_fwd ? s1_fwd_data : rd_data;
  assign bits      = cfbp_pkg::eff_bits(counter_bits);
  assign maxv      = cfbp_pkg::cnt_max(bits);
  assign lower     = maxv >> 2;
  assign upper     = maxv - lower - 8'd1;
  assign unconf    = (cur > lower) && (cur <= upper);
  assign top_set   = (cur >> (bits - 4'd1)) != '0;
  assign pred      = unconf ? s1_info.pp : top_set;

  always_comb begin
    cnt_next = cur;
    if (s1_info.taken) begin
      if (cur < maxv) begin
        cnt_next = cur + 8'd1;
      end
    end else if (cur != '0) begin
      cnt_next = cur - 8'd1;
    end
  end

  assign wr_en     = s1_valid && (s1_info.op == cfbp_pkg::OP_UPDATE) && !s1_info.squashed;
  assign s1_done   = s1_valid && (!is_lookup || !m_tvalid || m_tready);
  assign idx_ready = !clr_busy && (!s1_valid || s1_done);
  assign issue     = idx_valid && idx_ready;
  assign step_ok   = (cnt_next == cur) || (cnt_next == cur + 8'd1) || (cnt_next == cur - 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_bits <= cfbp_pkg::CFG_RESET;
    end else if (cfg_wen) begin
      counter_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  // read issued while the previous item writes the same entry: forward
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_index    <= idx_index;
      s1_info     <= idx_info;
      s1_fwd      <= wr_en && (s1_index == idx_index);
      s1_fwd_data <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_done && is_lookup) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && is_lookup) begin
      out_pred <= pred;
      out_used <= unconf;
    end
  end

  assign m_tdata = {6'd0, out_used, out_pred};

  `CFBP_ASSERT_NOW(a_no_issue_in_clear, clk, rst, clr_busy, !issue)
  `CFBP_ASSERT_NOW(a_stall_only_full, clk, rst, s1_valid && !s1_done, m_tvalid && !m_tready)
  `CFBP_ASSERT_NOW(a_step_of_one, clk, rst, wr_en, step_ok)

endmodule

@@ rtl/cfbp_index.sv @@
`timescale 1ns / 1ps
// Table index unit: (address >> INDEX_SHIFT) modulo TABLE_ENTRIES.
// Power-of-two sizes mask combinationally; others use a reciprocal multiply (states MUL, QUO, RMD).
// Depends on cfbp_pkg.
module cfbp_index #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int INDEX_SHIFT   = 2,
  parameter int IW            = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cfbp_pkg::ADDR_W-1:0]   in_addr,
  input  cfbp_pkg::item_info_t          in_info,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [IW-1:0]                 out_index,
  output cfbp_pkg::item_info_t          out_info
);

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  if (IS_POW2) begin : g_mask
    logic [cfbp_pkg::ADDR_W-1:0] shifted;

    assign shifted   = in_addr >> INDEX_SHIFT;
    assign out_index = shifted[IW-1:0];
    assign out_info  = in_info;
    assign out_valid = in_valid;
    assign in_ready  = out_ready;
  end else begin : g_rem
    typedef enum logic [2:0] {IDLE, MUL, QUO, RMD, DONE} state_t;

    localparam int AW = cfbp_pkg::ADDR_W;
    localparam int PW = 2 * AW;
    // unsigned division by a constant: q = (t + ((n - t) >> 1)) >> (IW - 1),
    // t = high half of n * MAGIC
    localparam logic [AW-1:0] MAGIC = AW'(((64'd1 << AW) * ((64'd1 << IW) -
                                      64'(TABLE_ENTRIES))) / 64'(TABLE_ENTRIES) + 64'd1);
    localparam logic [AW-1:0] DIV   = AW'(TABLE_ENTRIES);

    state_t                 state;
    logic [AW-1:0]          num;
    logic [AW-1:0]          hi;
    logic [AW-1:0]          quo;
    logic [IW-1:0]          rem;
    cfbp_pkg::item_info_t   info;
    logic [PW-1:0]          prod;
    logic [AW-1:0]          qn;
    logic [AW-1:0]          diff;
    logic [AW-1:0]          shifted;

    assign shifted = in_addr >> INDEX_SHIFT;
    assign prod    = PW'(num) * PW'(MAGIC);
    assign qn      = quo * DIV;
    assign diff    = num - qn;

    always_ff @(posedge clk) begin
      if (rst) begin
        state <= IDLE;
      end else begin
        case (state)
          IDLE: begin
            if (in_valid) begin
              state <= MUL;
              num   <= shifted;
              info  <= in_info;
            end
          end
          MUL: begin
            hi    <= prod[PW-1:AW];
            state <= QUO;
          end
          QUO: begin
            quo   <= (hi + ((num - hi) >> 1)) >> (IW - 1);
            state <= RMD;
          end
          RMD: begin
            rem   <= diff[IW-1:0];
            state <= DONE;
          end
          DONE: begin
            if (out_ready) begin
              state <= IDLE;
            end
          end
          default: state <= IDLE;
        endcase
      end
    end

    assign in_ready  = (state == IDLE);
    assign out_valid = (state == DONE);
    assign out_index = rem;
    assign out_info  = info;
  end

endmodule

@@ rtl/cfbp_table.sv @@
`timescale 1ns / 1ps
// Counter memory: one write and one registered read port, plus the
// post-reset clearing sweep. Depends on cfbp_pkg.
module cfbp_table #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int IW            = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  output logic                         clr_busy,
  input  logic                         rd_en,
  input  logic [IW-1:0]                rd_addr,
  output logic [cfbp_pkg::CNT_W-1:0]   rd_data,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic [cfbp_pkg::CNT_W-1:0]   wr_data
);

  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  logic [cfbp_pkg::CNT_W-1:0] mem [TABLE_ENTRIES];
  logic [IW-1:0]              clr_addr;
  logic                       we;
  logic [IW-1:0]              waddr;
  logic [cfbp_pkg::CNT_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_comb begin
    we    = wr_en;
    waddr = wr_addr;
    wdata = wr_data;
    if (clr_busy) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for confidence_filtered_bimodal_predictor_core: lookup and training
// beats go in with random bursts and gaps, and a counter table predicts each lookup.
// Depends on cfbp_pkg and the core RTL only.
module tb_top;

  localparam int TBL_N    = 1024;
  localparam int IDX_SH   = 2;
  localparam int TBL_BITS = $clog2(TBL_N);
  localparam int LIMIT    = 300000;
  localparam int AW       = cfbp_pkg::ADDR_W;
  localparam int CW       = cfbp_pkg::CNT_W;

  typedef struct packed {
    logic              op;
    logic [AW-1:0]     addr;
    logic              pp;
    logic              taken;
    logic              squashed;
  } branch_beat_t;

  typedef struct packed {
    logic taken;
    logic via_perceptron;
  } verdict_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [39:0]      s_tdata   = '0;   // branch_address[31:0], pp[32], taken[33], squashed[34]
  logic             s_tuser   = 1'b0; // operation[0]
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [7:0]       m_tdata;          // predicted_taken[0], used_perceptron[1]
  logic             cfg_wen   = 1'b0;
  logic [cfbp_pkg::CFG_W-1:0] cfg_wdata = '0;

  logic [CW-1:0]    conf_tbl [TBL_N];
  logic [cfbp_pkg::CFG_W-1:0] width_cfg = cfbp_pkg::CFG_RESET;
  verdict_t         verdict_q [$];
  verdict_t         want;

  int err_count   = 0;
  int out_count   = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int hold_req    = 0;
  int hold_left   = 0;
  int rx_mode     = 0;
  int rx_left     = 0;
  logic [TBL_BITS-1:0] hot_idx [4];

  confidence_filtered_bimodal_predictor_core #(
    .TABLE_ENTRIES(TBL_N),
    .INDEX_SHIFT  (IDX_SH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    foreach (conf_tbl[i]) conf_tbl[i] = '0;
  end

  function automatic int width_in_use();
    if (width_cfg == 0) begin
      return 1;
    end
    if (width_cfg > 8) begin
      return 8;
    end
    return int'(width_cfg);
  endfunction

  // counter table: lookups queue a verdict, unsquashed updates train
  function automatic void bimodal_step(branch_beat_t b);
    int w, top, lower, upper, c, slot;
    verdict_t v;
    w     = width_in_use();
    top   = (1 << w) - 1;
    slot  = int'((b.addr >> IDX_SH) % TBL_N);
    c     = int'(conf_tbl[slot]);
    if (b.op == cfbp_pkg::OP_LOOKUP) begin
      lower = top / 4;
      upper = top - lower - 1;
      v.via_perceptron = (c > lower) && (c <= upper);
      v.taken = v.via_perceptron ? b.pp : ((c >> (w - 1)) != 0);
      verdict_q.push_back(v);
    end else if (!b.squashed) begin
      if (b.taken) begin
        if (c < top) conf_tbl[slot] = CW'(c + 1);
      end else if (c > 0) begin
        conf_tbl[slot] = CW'(c - 1);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH %s: got %0d, expected %0d (output beat %0d)", what, got, exp_val,
             out_count);
    err_count++;
  endtask

  task automatic send_beat(input logic op, input logic [AW-1:0] addr, input logic pp,
                           input logic tk, input logic sq);
    int gap;
    branch_beat_t b;
    b = '{op: op, addr: addr, pp: pp, taken: tk, squashed: sq};
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, sq, tk, pp, addr};
    do @(posedge clk); while (!s_tready);
    bimodal_step(b);
  endtask

  task automatic set_counter_width(input logic [cfbp_pkg::CFG_W-1:0] bits);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    width_cfg  = bits;
    burst_left = 0;
  endtask

  function automatic logic [AW-1:0] hot_addr(input int n);
    logic [AW-1:0] a;
    a = $urandom;
    a[IDX_SH +: TBL_BITS] = hot_idx[$urandom_range(0, n - 1)];
    return a;
  endfunction

  task automatic test_reset_state();
    send_beat(cfbp_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    send_beat(cfbp_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
    send_beat(cfbp_pkg::OP_LOOKUP, 32'h8000_0003, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_train_saturate();
    logic [AW-1:0] a;
    a = 32'h0000_1234;
    repeat (2) send_beat(cfbp_pkg::OP_UPDATE, a, 1'b0, 1'b1, 1'b0);
    send_beat(cfbp_pkg::OP_UPDATE, a, 1'b1, 1'b1, 1'b0);
    send_beat(cfbp_pkg::OP_UPDATE, a ^ 32'h3, 1'b0, 1'b1, 1'b0);   // saturates at max
    send_beat(cfbp_pkg::OP_UPDATE, a, 1'b0, 1'b0, 1'b1);           // squashed, no training
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b0, 1'b0, 1'b0);
    send_beat(cfbp_pkg::OP_UPDATE, a, 1'b0, 1'b0, 1'b0);
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b0, 1'b0, 1'b0);
    send_beat(cfbp_pkg::OP_LOOKUP, a + 32'h1000, 1'b1, 1'b0, 1'b0); // aliases onto the entry
    repeat (3) send_beat(cfbp_pkg::OP_UPDATE, a, 1'b1, 1'b0, 1'b0); // floors at zero
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_width_extremes();
    logic [AW-1:0] a;
    a = 32'hFFFF_FFFC;
    repeat (3) send_beat(cfbp_pkg::OP_UPDATE, a, 1'b0, 1'b1, 1'b0);
    set_counter_width(4'd1);                              // counter now above max
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b0, 1'b0, 1'b0);
    send_beat(cfbp_pkg::OP_UPDATE, a, 1'b0, 1'b1, 1'b0);
    send_beat(cfbp_pkg::OP_UPDATE, a, 1'b0, 1'b0, 1'b0);
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b1, 1'b0, 1'b0);
    set_counter_width(4'd0);
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b0, 1'b0, 1'b0);
    set_counter_width(4'd15);
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b1, 1'b0, 1'b0);
    set_counter_width(4'd8);
    send_beat(cfbp_pkg::OP_UPDATE, a, 1'b1, 1'b1, 1'b0);
    send_beat(cfbp_pkg::OP_LOOKUP, a, 1'b0, 1'b0, 1'b0);
  endtask

  // counters drift one way for the first half of a phase, then back
  task automatic run_phase(input logic [cfbp_pkg::CFG_W-1:0] bits, input int n, input int hot_n,
                           input int taken_pct, input int update_pct);
    logic [AW-1:0] a;
    logic op;
    int   pct;
    set_counter_width(bits);
    foreach (hot_idx[k]) hot_idx[k] = TBL_BITS'($urandom_range(0, TBL_N - 1));
    for (int i = 0; i < n; i++) begin
      pct = (i < n / 2) ? taken_pct : 100 - taken_pct;
      a   = ($urandom_range(0, 99) < 85) ? hot_addr(hot_n) : AW'($urandom);
      op  = ($urandom_range(0, 99) < update_pct) ? cfbp_pkg::OP_UPDATE : cfbp_pkg::OP_LOOKUP;
      send_beat(op, a, 1'($urandom), $urandom_range(0, 99) < pct,
                $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic test_random_mix();
    run_phase(4'd2,  80,  4, 70, 50);
    run_phase(4'd8,  300, 1, 95, 80);
    run_phase(4'd1,  80,  4, 70, 50);
    run_phase(4'd3,  80,  3, 75, 60);
    run_phase(4'd15, 80,  2, 80, 60);
    run_phase(4'd0,  80,  4, 60, 40);
    run_phase(4'd5,  80,  2, 85, 70);
    run_phase(4'd4,  80,  3, 80, 60);
    run_phase(4'd7,  80,  2, 90, 70);
    run_phase(4'd6,  80,  4, 70, 50);
  endtask

  task automatic test_output_backpressure();
    set_counter_width(4'd2);
    foreach (hot_idx[k]) hot_idx[k] = TBL_BITS'($urandom_range(0, TBL_N - 1));
    gaps_on  = 1'b0;
    hold_req = 400;
    repeat (60) begin
      send_beat(($urandom_range(0, 4) == 0) ? cfbp_pkg::OP_UPDATE : cfbp_pkg::OP_LOOKUP,
                hot_addr(4), 1'($urandom), 1'($urandom), 1'b0);
    end
    gaps_on = 1'b1;
  endtask

  // receiver: random stall modes, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected beat, predicted_taken", int'(m_tdata[0]), 0);
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.taken)
          report_mismatch("predicted_taken", int'(m_tdata[0]), int'(want.taken));
        if (m_tdata[1] !== want.via_perceptron)
          report_mismatch("used_perceptron", int'(m_tdata[1]), int'(want.via_perceptron));
      end
      out_count++;
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_train_saturate();
    test_width_extremes();
    test_random_mix();
    test_output_backpressure();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cfbp_pkg.sv
rtl/cfbp_index.sv
rtl/cfbp_table.sv
rtl/confidence_filtered_bimodal_predictor_core.sv
tb/tb_top.sv
